>>> sv/lhn_pkg.sv
`default_nettype none

package lhn_pkg;

   localparam int INDEX_BITS_DEF = 16;
   localparam int MAX_DEPTH_DEF  = 16;

   localparam int EXTRA_W = 4;
   localparam int COUNT_W = 5;
   localparam int BND_W   = 2;

   typedef logic signed [BND_W-1:0] bnd_type;

   localparam bnd_type BND_NONE  = 2'sb00;
   localparam bnd_type BND_UPPER = 2'sb01;
   localparam bnd_type BND_LOWER = 2'sb11;

endpackage

`default_nettype wire

>>> sv/layer_hierarchy_navigator.sv
// Pipeline from item taken to result valid: one register stage for each level step and each
// boundary step, plus setup and output.
// Throughput: one item per cycle; a held result freezes every stage, bubbles included.
// Reset (synchronous, active high) clears all stage valid bits and sets extra_layers to 0.
`default_nettype none

module layer_hierarchy_navigator import lhn_pkg::*; #(
   parameter int INDEX_BITS = INDEX_BITS_DEF,
   parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
   localparam int DEPTH_W = $clog2(INDEX_BITS + 1),
   localparam int PAR_W   = INDEX_BITS + 1,
   localparam int FIRST_W = INDEX_BITS + 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [EXTRA_W-1:0]        csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [INDEX_BITS-1:0]     req_layer_index,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [DEPTH_W-1:0]        rsp_depth,
   output logic                      rsp_is_degenerate,
   output logic                      rsp_is_end,
   output logic                      rsp_is_degenerate_child,
   output bnd_type                   rsp_boundary,
   output logic signed [PAR_W-1:0]   rsp_parent,
   output logic [FIRST_W-1:0]        rsp_first_child,
   output logic [COUNT_W-1:0]        rsp_child_count,
   output logic signed [PAR_W-1:0]   rsp_above,
   output logic signed [PAR_W-1:0]   rsp_below
);

   localparam int LAST_W = INDEX_BITS + 2;
   localparam int TOP_W  = INDEX_BITS + 3;
   localparam int PROD_W = DEPTH_W + EXTRA_W;

   logic [EXTRA_W-1:0] extra_layers_ff;
   logic               advance;

   logic                    rsp_valid_ff;
   logic [DEPTH_W-1:0]      rsp_depth_ff;
   logic                    rsp_degen_ff;
   logic                    rsp_end_ff;
   logic                    rsp_dchild_ff;
   bnd_type                 rsp_bnd_ff;
   logic signed [PAR_W-1:0] rsp_parent_ff;
   logic [FIRST_W-1:0]      rsp_first_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;
   logic signed [PAR_W-1:0] rsp_above_ff;
   logic signed [PAR_W-1:0] rsp_below_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         extra_layers_ff <= '0;
      end else if (csr_we) begin
         extra_layers_ff <= csr_wdata;
      end
   end

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // level walk: one stage per level
   logic                  lv_v_ff     [1:INDEX_BITS];
   logic [INDEX_BITS-1:0] lv_l_ff     [1:INDEX_BITS];
   logic [LAST_W-1:0]     lv_last_ff  [1:INDEX_BITS];
   logic [DEPTH_W-1:0]    lv_depth_ff [1:INDEX_BITS];
   logic                  lv_degen_ff [1:INDEX_BITS];

   for (genvar k = 0; k < INDEX_BITS; k++) begin : g_level
      logic                  cur_v;
      logic [INDEX_BITS-1:0] cur_l;
      logic [LAST_W-1:0]     cur_last;
      logic [DEPTH_W-1:0]    cur_depth;
      logic                  cur_degen;
      logic                  run;
      logic [LAST_W-1:0]     last_in;
      logic [DEPTH_W-1:0]    depth_in;
      logic                  degen_in;

      if (k == 0) begin : g_head
         assign cur_v     = req_valid;
         assign cur_l     = req_layer_index;
         assign cur_last  = '0;
         assign cur_depth = '0;
         assign cur_degen = (req_layer_index == '0);
      end else begin : g_body
         assign cur_v     = lv_v_ff[k];
         assign cur_l     = lv_l_ff[k];
         assign cur_last  = lv_last_ff[k];
         assign cur_depth = lv_depth_ff[k];
         assign cur_degen = lv_degen_ff[k];
      end

      always_comb begin
         run      = LAST_W'(cur_l) > cur_last;
         degen_in = cur_degen || (run && (LAST_W'(cur_l) == cur_last + LAST_W'(1)));
         last_in  = run ? (cur_last << 1) + LAST_W'(extra_layers_ff) * LAST_W'(k + 1)
                          + LAST_W'(2)
                        : cur_last;
         depth_in = run ? DEPTH_W'(k + 1) : cur_depth;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            lv_v_ff[k+1] <= 1'b0;
         end else if (advance) begin
            lv_v_ff[k+1] <= cur_v;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            lv_l_ff[k+1]     <= cur_l;
            lv_last_ff[k+1]  <= last_in;
            lv_depth_ff[k+1] <= depth_in;
            lv_degen_ff[k+1] <= degen_in;
         end
      end
   end

   // setup of the boundary walk
   logic [TOP_W-1:0]        e1;
   logic [TOP_W-1:0]        e1_sh;
   logic                    setup_end_in;
   logic                    setup_dchild_in;
   logic [TOP_W-1:0]        setup_inc_in;
   logic signed [TOP_W-1:0] setup_top_in;
   logic [PROD_W-1:0]       setup_de_in;
   logic [PAR_W-1:0]        setup_pd_in;

   always_comb begin
      e1              = TOP_W'(extra_layers_ff) + TOP_W'(1);
      e1_sh           = e1 << (lv_depth_ff[INDEX_BITS] - DEPTH_W'(1));
      setup_end_in    = (lv_depth_ff[INDEX_BITS] != '0)
                        && (LAST_W'(lv_l_ff[INDEX_BITS]) == lv_last_ff[INDEX_BITS]);
      setup_dchild_in = (lv_depth_ff[INDEX_BITS] == DEPTH_W'(1));
      setup_inc_in    = (lv_depth_ff[INDEX_BITS] == '0) ? (e1 >> 1) : e1_sh;
      setup_top_in    = $signed(TOP_W'(lv_last_ff[INDEX_BITS]));
      setup_de_in     = PROD_W'(extra_layers_ff) * PROD_W'(lv_depth_ff[INDEX_BITS]);
      setup_pd_in     = PAR_W'(e1_sh - e1 - TOP_W'(setup_de_in) + TOP_W'(extra_layers_ff));
   end

   // boundary walk: one stage per step
   logic                    bd_v_ff      [0:MAX_DEPTH];
   logic [INDEX_BITS-1:0]   bd_l_ff      [0:MAX_DEPTH];
   logic [DEPTH_W-1:0]      bd_depth_ff  [0:MAX_DEPTH];
   logic                    bd_degen_ff  [0:MAX_DEPTH];
   logic                    bd_end_ff    [0:MAX_DEPTH];
   logic                    bd_dchild_ff [0:MAX_DEPTH];
   logic signed [TOP_W-1:0] bd_top_ff    [0:MAX_DEPTH];
   logic [TOP_W-1:0]        bd_inc_ff    [0:MAX_DEPTH];
   bnd_type                 bd_bnd_ff    [0:MAX_DEPTH];
   logic                    bd_act_ff    [0:MAX_DEPTH];
   logic [PROD_W-1:0]       bd_de_ff     [0:MAX_DEPTH];
   logic [PAR_W-1:0]        bd_pd_ff     [0:MAX_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         bd_v_ff[0] <= 1'b0;
      end else if (advance) begin
         bd_v_ff[0] <= lv_v_ff[INDEX_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bd_l_ff[0]      <= lv_l_ff[INDEX_BITS];
         bd_depth_ff[0]  <= lv_depth_ff[INDEX_BITS];
         bd_degen_ff[0]  <= lv_degen_ff[INDEX_BITS];
         bd_end_ff[0]    <= setup_end_in;
         bd_dchild_ff[0] <= setup_dchild_in;
         bd_top_ff[0]    <= setup_top_in;
         bd_inc_ff[0]    <= setup_inc_in;
         bd_bnd_ff[0]    <= BND_NONE;
         bd_act_ff[0]    <= 1'b1;
         bd_de_ff[0]     <= setup_de_in;
         bd_pd_ff[0]     <= setup_pd_in;
      end
   end

   for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_bound
      logic signed [TOP_W-1:0] li;
      logic signed [TOP_W-1:0] top_n;
      logic                    go;
      logic                    hit_lo;
      logic                    hit_hi;
      logic                    dchild_in;
      bnd_type                 bnd_in;
      logic                    act_in;
      logic signed [TOP_W-1:0] top_in;
      logic [TOP_W-1:0]        inc_in;

      always_comb begin
         li        = $signed(TOP_W'(bd_l_ff[i]));
         top_n     = bd_top_ff[i] - $signed(bd_inc_ff[i]);
         go        = bd_act_ff[i] && (li <= bd_top_ff[i] + $signed(TOP_W'(1)));
         hit_lo    = (li == top_n);
         hit_hi    = (li == top_n + $signed(TOP_W'(1)));
         dchild_in = bd_dchild_ff[i]
                     || (go && (32'(bd_depth_ff[i]) == 32'(i + 2)) && (li <= top_n));
         bnd_in    = bd_bnd_ff[i];
         if (go && hit_lo) begin
            bnd_in = BND_LOWER;
         end else if (go && hit_hi) begin
            bnd_in = BND_UPPER;
         end
         act_in    = go && !hit_lo && !hit_hi;
         top_in    = go ? top_n : bd_top_ff[i];
         inc_in    = bd_inc_ff[i] >> 1;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            bd_v_ff[i+1] <= 1'b0;
         end else if (advance) begin
            bd_v_ff[i+1] <= bd_v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            bd_l_ff[i+1]      <= bd_l_ff[i];
            bd_depth_ff[i+1]  <= bd_depth_ff[i];
            bd_degen_ff[i+1]  <= bd_degen_ff[i];
            bd_end_ff[i+1]    <= bd_end_ff[i];
            bd_dchild_ff[i+1] <= dchild_in;
            bd_top_ff[i+1]    <= top_in;
            bd_inc_ff[i+1]    <= inc_in;
            bd_bnd_ff[i+1]    <= bnd_in;
            bd_act_ff[i+1]    <= act_in;
            bd_de_ff[i+1]     <= bd_de_ff[i];
            bd_pd_ff[i+1]     <= bd_pd_ff[i];
         end
      end
   end

   // neighbors and output register
   logic signed [TOP_W-1:0] f_li;
   logic signed [TOP_W-1:0] f_x;
   logic signed [TOP_W-1:0] f_xh;
   logic signed [PAR_W-1:0] parent_in;
   logic [FIRST_W-1:0]      first_in;
   logic [COUNT_W-1:0]      count_in;
   logic signed [PAR_W-1:0] above_in;
   logic signed [PAR_W-1:0] below_in;

   always_comb begin
      f_li = $signed(TOP_W'(bd_l_ff[MAX_DEPTH]));
      f_x  = f_li - $signed(TOP_W'(bd_de_ff[MAX_DEPTH])) - $signed(TOP_W'(1));
      f_xh = (f_x + $signed(TOP_W'(f_x[TOP_W-1]))) >>> 1;
      if (bd_l_ff[MAX_DEPTH] == '0) begin
         parent_in = '1;
      end else if (bd_dchild_ff[MAX_DEPTH]) begin
         parent_in = bd_pd_ff[MAX_DEPTH];
      end else begin
         parent_in = PAR_W'(f_xh);
      end
      first_in = FIRST_W'((TOP_W'(bd_l_ff[MAX_DEPTH]) << 1) + TOP_W'(bd_de_ff[MAX_DEPTH])
                          + TOP_W'(1)
                          + (bd_degen_ff[MAX_DEPTH] ? '0 : TOP_W'(extra_layers_ff)));
      count_in = bd_degen_ff[MAX_DEPTH] ? COUNT_W'(extra_layers_ff) + COUNT_W'(2)
                                        : COUNT_W'(2);
      above_in = bd_end_ff[MAX_DEPTH] ? '1
                                      : PAR_W'(bd_l_ff[MAX_DEPTH]) + PAR_W'(1);
      below_in = bd_degen_ff[MAX_DEPTH] ? '1
                                        : PAR_W'(bd_l_ff[MAX_DEPTH]) - PAR_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= bd_v_ff[MAX_DEPTH];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_depth_ff  <= bd_depth_ff[MAX_DEPTH];
         rsp_degen_ff  <= bd_degen_ff[MAX_DEPTH];
         rsp_end_ff    <= bd_end_ff[MAX_DEPTH];
         rsp_dchild_ff <= bd_dchild_ff[MAX_DEPTH];
         rsp_bnd_ff    <= bd_bnd_ff[MAX_DEPTH];
         rsp_parent_ff <= parent_in;
         rsp_first_ff  <= first_in;
         rsp_count_ff  <= count_in;
         rsp_above_ff  <= above_in;
         rsp_below_ff  <= below_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_depth               = rsp_depth_ff;
   assign rsp_is_degenerate       = rsp_degen_ff;
   assign rsp_is_end              = rsp_end_ff;
   assign rsp_is_degenerate_child = rsp_dchild_ff;
   assign rsp_boundary            = rsp_bnd_ff;
   assign rsp_parent              = rsp_parent_ff;
   assign rsp_first_child         = rsp_first_ff;
   assign rsp_child_count         = rsp_count_ff;
   assign rsp_above               = rsp_above_ff;
   assign rsp_below               = rsp_below_ff;

`ifndef NO_ASSERTIONS
   a_root_layer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_depth == '0)
      |-> rsp_is_degenerate && !rsp_is_end && (rsp_parent == '1))
      else $error("depth-zero item is not the root layer");

   a_first_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_depth == DEPTH_W'(1))
      |-> rsp_is_degenerate_child && (rsp_parent == '0))
      else $error("first-level item does not descend from the root");

   a_neighbors: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_degenerate && !rsp_is_end
      |-> (rsp_above - rsp_below) == $signed(PAR_W'(2)))
      else $error("inner layer neighbors are not two apart");
`endif

endmodule

`default_nettype wire
